// ----- src/nsfbd_pkg.sv -----
// types and address map constants for the music player bus decoder
package nsfbd_pkg;

    // request layout: op, addr, data, rom_offset from the lowest bit up
    localparam int unsigned OP_W    = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OFF_W   = 20;
    localparam int unsigned SREG_W  = 5;
    localparam int unsigned IN_W    = OP_W + ADDR_W + BYTE_W + OFF_W;
    localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int unsigned OUT_W   = BYTE_W + 1 + SREG_W + BYTE_W;
    localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;

    localparam int unsigned WRAM_AW = 11;
    localparam int unsigned XRAM_AW = 13;
    localparam int unsigned CC_AW   = 4;
    localparam int unsigned BANK_N  = 8;
    localparam int unsigned PAGE_AW = 12;

    localparam logic [ADDR_W-1:0] WRAM_END = 16'h2000;
    localparam logic [ADDR_W-1:0] SND_LO   = 16'h4000;
    localparam logic [ADDR_W-1:0] SND_HI   = 16'h4017;
    localparam logic [ADDR_W-1:0] CC_LO    = 16'h4F80;
    localparam logic [ADDR_W-1:0] CC_END   = 16'h4F90;
    localparam logic [ADDR_W-1:0] BANK_LO  = 16'h5FF8;
    localparam logic [ADDR_W-1:0] BANK_HI  = 16'h5FFF;
    localparam logic [ADDR_W-1:0] XRAM_LO  = 16'h6000;
    localparam logic [ADDR_W-1:0] XRAM_END = 16'h8000;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_WRAM,
        SRC_CCODE,
        SRC_XRAM,
        SRC_ROM
    } src_t;

endpackage

// ----- src/nsf_bus_decoder_bankswitch.sv -----
// bus decoder and 4 KB bank switcher for a music player 6502 bus
//
// one request channel (s_*) carries a bus read, a bus write or a rom image load;
// one response channel (m_*) returns exactly one response per request, in order.
// an accepted request passes through one read of the on-chip memories (work
// ram, call code, extra ram, banked rom), each with a registered read port, into
// the pending registers; the response is then held in an output register until
// taken. with the response side ready the block takes one request per cycle,
// so throughput is 1 request a cycle. when the receiver stalls, one request may
// still sit behind the output register; s_tready drops until the output register
// frees up. after reset a clearing pass zeroes work ram and extra ram, one entry
// a cycle across the 8192 extra ram addresses, and s_tready stays low meanwhile.
// bank registers reset to bank 0; call code and rom contents are undefined until
// written. bank numbers written at 0x5ff8..0x5fff wrap modulo ROM_BANKS.
module nsf_bus_decoder_bankswitch #(
    parameter int unsigned ROM_BANKS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // op[1:0], addr[17:2], data[25:18], rom_offset[45:26]
    input  logic [nsfbd_pkg::IN_TW-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_data[7:0], sound_write[8], sound_reg[13:9], sound_data[21:14]
    output logic [nsfbd_pkg::OUT_TW-1:0] m_tdata
);
    import nsfbd_pkg::*;

    localparam int unsigned BANK_W    = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
    localparam int unsigned ROM_AW    = BANK_W + PAGE_AW;
    localparam int unsigned ROM_BYTES = ROM_BANKS * (2 ** PAGE_AW);
    localparam int unsigned CLR_W     = XRAM_AW;

    // memories
    logic [BYTE_W-1:0] wram_mem [2 ** WRAM_AW];
    logic [BYTE_W-1:0] xram_mem [2 ** XRAM_AW];
    logic [BYTE_W-1:0] cc_mem   [2 ** CC_AW];
    logic [BYTE_W-1:0] rom_mem  [ROM_BYTES];

    logic [BYTE_W-1:0] wram_q;
    logic [BYTE_W-1:0] xram_q;
    logic [BYTE_W-1:0] cc_q;
    logic [BYTE_W-1:0] rom_q;

    logic [BANK_W-1:0] bank_reg [BANK_N];
    logic [BANK_W-1:0] bank_mod [2 ** BYTE_W];

    logic              clr_active_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    logic              p_valid_reg;
    src_t              p_src_reg;
    logic              p_snd_reg;
    logic [SREG_W-1:0] p_sreg_reg;
    logic [BYTE_W-1:0] p_sdata_reg;
    src_t              p_src_next;
    logic              p_snd_next;

    logic              out_valid_reg;
    logic [OUT_TW-1:0] out_data_reg;
    logic [OUT_TW-1:0] out_data_next;
    logic [BYTE_W-1:0] rd_byte;

    logic [OP_W-1:0]   in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_data;
    logic [OFF_W-1:0]  in_off;

    logic accept;
    logic p_move;
    logic is_wram;
    logic is_snd;
    logic is_cc;
    logic is_bank;
    logic is_xram;
    logic is_rom;
    logic load_ok;

    logic              wram_we;
    logic              xram_we;
    logic              cc_we;
    logic              rom_we;
    logic              bank_we;
    logic [WRAM_AW-1:0] wram_wa;
    logic [XRAM_AW-1:0] xram_wa;
    logic [BYTE_W-1:0]  ram_wd;
    logic [ROM_AW-1:0]  rom_ra;

    // bank number modulo table, constant
    for (genvar g = 0; g < 2 ** BYTE_W; g++)
    begin : g_bank_mod
        localparam int unsigned BankVal = g % ROM_BANKS;
        assign bank_mod[g] = BANK_W'(BankVal);
    end

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_addr = s_tdata[OP_W+ADDR_W-1:OP_W];
    assign in_data = s_tdata[OP_W+ADDR_W+BYTE_W-1:OP_W+ADDR_W];
    assign in_off  = s_tdata[IN_W-1:OP_W+ADDR_W+BYTE_W];

    assign is_wram = in_addr < WRAM_END;
    assign is_snd  = (in_addr >= SND_LO) && (in_addr <= SND_HI);
    assign is_cc   = (in_addr >= CC_LO) && (in_addr < CC_END);
    assign is_bank = (in_addr >= BANK_LO) && (in_addr <= BANK_HI);
    assign is_xram = (in_addr >= XRAM_LO) && (in_addr < XRAM_END);
    assign is_rom  = in_addr >= XRAM_END;
    assign load_ok = {1'b0, in_off} < (OFF_W + 1)'(ROM_BYTES);

    assign p_move   = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!p_valid_reg || p_move);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        wram_we    = 1'b0;
        xram_we    = 1'b0;
        cc_we      = 1'b0;
        rom_we     = 1'b0;
        bank_we    = 1'b0;
        p_src_next = SRC_NONE;
        p_snd_next = 1'b0;
        case (in_op)
            OP_READ:
            begin
                if (is_wram)
                    p_src_next = SRC_WRAM;
                else if (is_cc)
                    p_src_next = SRC_CCODE;
                else if (is_xram)
                    p_src_next = SRC_XRAM;
                else if (is_rom)
                    p_src_next = SRC_ROM;
            end
            OP_WRITE:
            begin
                wram_we    = accept && is_wram;
                xram_we    = accept && is_xram;
                cc_we      = accept && is_cc;
                bank_we    = accept && is_bank;
                p_snd_next = is_snd;
            end
            OP_LOAD:
            begin
                rom_we = accept && load_ok;
            end
            default:
            begin
                p_src_next = SRC_NONE;
            end
        endcase
    end

    // clearing pass shares the ram write ports
    assign wram_wa = clr_active_reg ? clr_cnt_reg[WRAM_AW-1:0] : in_addr[WRAM_AW-1:0];
    assign xram_wa = clr_active_reg ? clr_cnt_reg : in_addr[XRAM_AW-1:0];
    assign ram_wd  = clr_active_reg ? '0 : in_data;
    assign rom_ra  = {bank_reg[in_addr[PAGE_AW+2:PAGE_AW]], in_addr[PAGE_AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (clr_active_reg || wram_we)
            wram_mem[wram_wa] <= ram_wd;
        if (accept)
            wram_q <= wram_mem[in_addr[WRAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg || xram_we)
            xram_mem[xram_wa] <= ram_wd;
        if (accept)
            xram_q <= xram_mem[in_addr[XRAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cc_we)
            cc_mem[in_addr[CC_AW-1:0]] <= in_data;
        if (accept)
            cc_q <= cc_mem[in_addr[CC_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rom_we)
            rom_mem[in_off[ROM_AW-1:0]] <= in_data;
        if (accept)
            rom_q <= rom_mem[rom_ra];
    end

    always_comb
    begin
        case (p_src_reg)
            SRC_WRAM:  rd_byte = wram_q;
            SRC_CCODE: rd_byte = cc_q;
            SRC_XRAM:  rd_byte = xram_q;
            SRC_ROM:   rd_byte = rom_q;
            default:   rd_byte = '0;
        endcase
        out_data_next = OUT_TW'({p_sdata_reg, p_sreg_reg, p_snd_reg, rd_byte});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < BANK_N; i++)
                bank_reg[i] <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    clr_active_reg <= 1'b0;
            end
            if (bank_we)
                bank_reg[in_addr[2:0]] <= bank_mod[in_data];
            if (accept)
                p_valid_reg <= 1'b1;
            else if (p_move)
                p_valid_reg <= 1'b0;
            if (p_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_src_reg   <= p_src_next;
            p_snd_reg   <= p_snd_next;
            p_sreg_reg  <= p_snd_next ? in_addr[SREG_W-1:0] : '0;
            p_sdata_reg <= p_snd_next ? in_data : '0;
        end
        if (p_move)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // no request taken while the rams are being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // a pending request whose response cannot move keeps its memory read
    a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && out_valid_reg && !m_tready) |=>
            (p_valid_reg && $stable(p_src_reg) && (rom_q === $past(rom_q))
                && (wram_q === $past(wram_q))))
        else $error("pending request lost while response stalled");

    // a forwarded sound write never carries read data
    a_snd_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_snd_reg) |-> (p_src_reg == SRC_NONE))
        else $error("sound write decoded as a read");

    // a response without a sound write has its sound fields zero
    a_snd_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[BYTE_W]) |->
            (out_data_reg[OUT_W-1:BYTE_W+1] == '0))
        else $error("sound fields set without sound write");

endmodule
